/* design/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the character classifier of the base64 decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QUEUE_DEPTH = 4;

  // one character transaction from the source
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_string;
  } in_item_t;

  // one result transaction to the sink
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       string_done;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_DATA = 2'd1,
    KIND_PAD  = 2'd2
  } kind_t;

  // classified character as it travels through the queue
  typedef struct packed {
    kind_t      kind;
    logic [5:0] sextet;
    logic       last;
  } class_item_t;

  typedef struct packed {
    logic nonempty;
    logic full;
  } queue_status_t;

  // map a character onto its alphabet value; whitespace and others are skipped
  function automatic class_item_t classify(input in_item_t it);
    class_item_t r;
    r.kind   = KIND_SKIP;
    r.sextet = '0;
    r.last   = it.end_of_string;
    if (it.in_char inside {[8'h41:8'h5A]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(it.in_char - 8'h41);
    end else if (it.in_char inside {[8'h61:8'h7A]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(it.in_char - 8'h61 + 8'd26);
    end else if (it.in_char inside {[8'h30:8'h39]}) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'(it.in_char - 8'h30 + 8'd52);
    end else if (it.in_char == 8'h2B) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'd62;
    end else if (it.in_char == 8'h2F) begin
      r.kind   = KIND_DATA;
      r.sextet = 6'd63;
    end else if (it.in_char == PAD_CHAR) begin
      r.kind   = KIND_PAD;
    end
    return r;
  endfunction

endpackage

/* design/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// accepts characters, classifies them and holds one entry for the queue
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        chr_valid,
  output logic        chr_stall,
  input  in_item_t    chr_data,
  input  logic        q_full,
  output logic        fr_valid,
  output class_item_t fr_item
);

  assign chr_stall = fr_valid && q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (!chr_stall) begin
      fr_valid <= chr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!chr_stall && chr_valid) begin
      fr_item <= classify(chr_data);
    end
  end

endmodule

/* design/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// short fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  class_item_t   push_item,
  input  logic          pop,
  output class_item_t   head_item,
  output queue_status_t status
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  class_item_t         entries [Depth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push;
  logic                do_pop;

  assign status.nonempty = (count != '0);
  assign status.full     = (count == FullCnt);
  assign do_push         = push && !status.full;
  assign do_pop          = pop && status.nonempty;
  assign head_item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

/* design/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// bit packing state, byte extraction and the result register
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t q_status,
  input  class_item_t   head_item,
  output logic          pop,
  output logic          res_valid,
  input  logic          res_stall,
  output out_item_t     res_data
);

  logic [11:0] bit_accumulator;
  logic [11:0] bit_accumulator_next;
  logic [2:0]  bits_held;
  logic [2:0]  bits_held_next;
  logic        pad_seen;
  logic        pad_seen_next;
  logic [3:0]  held;
  logic [2:0]  shift;
  out_item_t   result;

  assign pop = q_status.nonempty && (!res_valid || !res_stall);

  always_comb begin
    bit_accumulator_next = bit_accumulator;
    bits_held_next       = bits_held;
    pad_seen_next        = pad_seen;
    held                 = {1'b0, bits_held} + 4'd6;
    shift                = 3'(held - 4'd8);
    result.byte_valid    = 1'b0;
    result.out_byte      = '0;
    result.string_done   = head_item.last;
    if (!pad_seen) begin
      case (head_item.kind)
        KIND_PAD: begin
          pad_seen_next = 1'b1;
        end
        KIND_DATA: begin
          bit_accumulator_next = {bit_accumulator[5:0], head_item.sextet};
          if (held >= 4'd8) begin
            result.byte_valid = 1'b1;
            result.out_byte   = 8'(bit_accumulator_next >> shift);
            bits_held_next    = shift;
          end else begin
            bits_held_next    = held[2:0];
          end
        end
        default: begin
        end
      endcase
    end
    // end of string drops leftover bits
    if (head_item.last) begin
      bit_accumulator_next = '0;
      bits_held_next       = '0;
      pad_seen_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_accumulator <= '0;
      bits_held       <= '0;
      pad_seen        <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      if (pop) begin
        bit_accumulator <= bit_accumulator_next;
        bits_held       <= bits_held_next;
        pad_seen        <= pad_seen_next;
      end
      if (!res_valid || !res_stall) begin
        res_valid <= q_status.nonempty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_data <= result;
    end
  end

endmodule

/* design/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// streaming base64 decoder, standard alphabet, one result per character
// ----------------------------------------------------------------------------
//  channel | signals                         | transaction
//  chr     | chr_valid, chr_stall, chr_data  | one character and end flag in
//  res     | res_valid, res_stall, res_data  | byte flag, byte, string done out
//
//  one character per cycle while chr_stall is low; a result passes through the
//  classify register, a queue entry and the result register before it is
//  valid.
//  the queue of QueueDepth entries absorbs sink stalls; chr_stall rises only
//  when the classify register is full and the queue is full.
//  synchronous reset clears the queue, the handshake state and the decoder
//  state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      chr_valid,
  output logic      chr_stall,
  input  in_item_t  chr_data,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res_data
);

  logic          fr_valid;
  class_item_t   fr_item;
  class_item_t   head_item;
  queue_status_t q_status;
  logic          q_pop;

  b64d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_data  (chr_data),
    .q_full    (q_status.full),
    .fr_valid  (fr_valid),
    .fr_item   (fr_item)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (fr_valid),
    .push_item (fr_item),
    .pop       (q_pop),
    .head_item (head_item),
    .status    (q_status)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head_item (head_item),
    .pop       (q_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  // a full queue is never empty
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && !q_status.nonempty))
    else $error("queue reports full and empty");

  // input only stalls while a classified character waits for room
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    chr_stall |-> (fr_valid && q_status.full))
    else $error("input stalled without a waiting entry");

  // a pop always lands in the result register
  a_pop_result: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> res_valid)
    else $error("popped character produced no result");

  // results only come from queued characters
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !$past(res_valid)) |-> $past(q_status.nonempty))
    else $error("result without queued character");

endmodule

/* dv/base64_stream_decoder_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// feeds base64 text character by character through the decoder and checks
// every result transaction against a decoder model kept inside the bench;
// directed corner strings first, then random strings with source gaps, sink
// stalls, a streaming stretch and a long sink hold that backs up the input
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
  import b64d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SO        = 8'h0E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam int         LONG_HOLD    = 80;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         MAX_REPORTS  = 10;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      chr_valid = 1'b0;
  logic      chr_stall;
  in_item_t  chr_data = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res_data;

  // decoder state as seen by the bench
  logic [11:0] model_bits = '0;
  logic [2:0]  model_count = '0;
  logic        model_padded = 1'b0;

  out_item_t   pending_results[$];
  int          error_count = 0;
  int          useful_chars = 0;
  bit          src_gaps_on = 1'b0;
  logic        sink_idle_on = 1'b0;
  logic        sink_held = 1'b0;
  event        long_hold;

  base64_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr_data  (chr_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // alphabet value of a character, -1 when it is not part of the alphabet
  function automatic int sextet_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < 26) return 8'h41 + 8'(v);
    if (v < 52) return 8'h61 + 8'(v - 26);
    if (v < 62) return 8'h30 + 8'(v - 52);
    if (v == 62) return 8'h2B;
    return 8'h2F;
  endfunction

  function automatic logic [7:0] random_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // advance the model by one character and return the result it yields
  function automatic out_item_t decode_char(input in_item_t it);
    out_item_t r;
    int        v;
    int        n;
    r = '0;
    r.string_done = it.end_of_string;
    if (!model_padded && !(it.in_char inside {[CH_TAB:CH_CR], CH_SPACE})) begin
      if (it.in_char == PAD_CHAR) begin
        model_padded = 1'b1;
      end else begin
        v = sextet_value(it.in_char);
        if (v >= 0) begin
          n = int'(model_count) + 6;
          model_bits = {model_bits[5:0], 6'(v)};
          if (n >= 8) begin
            n -= 8;
            r.byte_valid = 1'b1;
            r.out_byte = 8'(model_bits >> n);
          end
          model_count = 3'(n);
        end
      end
    end
    if (it.end_of_string) begin
      model_bits = '0;
      model_count = '0;
      model_padded = 1'b0;
    end
    return r;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic last);
    in_item_t it;
    it.in_char = c;
    it.end_of_string = last;
    if (src_gaps_on && $urandom_range(99) < 15) begin
      chr_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    chr_valid <= 1'b1;
    chr_data <= it;
    do @(posedge clk); while (chr_stall);
    pending_results = {pending_results, decode_char(it)};
    if (last || c == PAD_CHAR || sextet_value(c) >= 0) useful_chars++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], close && i == s.len() - 1);
  endtask

  // mostly well-formed encodings, some broken strings, some pure noise
  task automatic send_random_string();
    logic [7:0]  txt[$];
    logic [23:0] grp;
    int          style;
    int          n;
    int          k;
    bit          blank_tail;
    style = $urandom_range(99);
    if (style < 70) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i += 3) begin
        grp = 24'($urandom());
        k = (n - i >= 3) ? 4 : n - i + 1;
        for (int j = 0; j < 4; j++) begin
          if (j < k) txt = {txt, sextet_char(grp[23 - 6 * j -: 6])};
          else if ($urandom_range(9) != 0) txt = {txt, PAD_CHAR};
        end
      end
      // trailing characters after padding must be dropped
      if ($urandom_range(9) == 0) txt = {txt, sextet_char(6'($urandom()))};
    end else if (style < 85) begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        k = $urandom_range(9);
        if (k < 8) txt = {txt, sextet_char(6'($urandom()))};
        else if (k == 8) txt = {txt, PAD_CHAR};
        else txt = {txt, 8'($urandom_range(255))};
      end
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) txt = {txt, 8'($urandom_range(255))};
    end
    blank_tail = ($urandom_range(19) == 0);
    foreach (txt[i]) begin
      if (style < 70 && $urandom_range(99) < 8) send_char(random_blank(), 1'b0);
      send_char(txt[i], !blank_tail && i == txt.size() - 1);
    end
    if (blank_tail) send_char(random_blank(), 1'b1);
  endtask

  task automatic test_directed();
    src_gaps_on = 1'b0;
    sink_idle_on <= 1'b0;
    send_text("TWFu", 1'b1);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_LBRACE, 1'b0);
    send_char(CH_AT, 1'b0);
    send_char(CH_BACKSPACE, 1'b0);
    send_char(CH_SO, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_text("A", 1'b0);
    send_char(CH_CR, 1'b0);
    send_text("/", 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_text("+z09aZ", 1'b0);
    send_char(PAD_CHAR, 1'b0);
    send_text("Qw", 1'b1);
    // end flag on a completing char, on a partial char, on blank and on pad
    send_text("QQ", 1'b1);
    send_text("Q", 1'b1);
    send_char(CH_SPACE, 1'b1);
    send_char(PAD_CHAR, 1'b1);
  endtask

  task automatic test_random_strings(input int quota, input bit with_idle);
    int stop_at;
    src_gaps_on = with_idle;
    sink_idle_on <= with_idle;
    stop_at = useful_chars + quota;
    while (useful_chars < stop_at) send_random_string();
  endtask

  task automatic test_backpressure();
    src_gaps_on = 1'b0;
    sink_idle_on <= 1'b0;
    -> long_hold;
    repeat (12) send_random_string();
  endtask

  // sink hold, counted here so that the source keeps offering meanwhile
  initial forever begin
    @(long_hold);
    sink_held <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    sink_held <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (sink_held) begin
      res_stall <= 1'b1;
    end else begin
      res_stall <= sink_idle_on && ($urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result transaction: valid=%0b byte=%02h done=%0b",
                   res_data.byte_valid, res_data.out_byte, res_data.string_done);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_data.byte_valid !== want.byte_valid ||
            res_data.out_byte !== want.out_byte ||
            res_data.string_done !== want.string_done) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: expected %0b/%02h/%0b, got %0b/%02h/%0b",
                     want.byte_valid, want.out_byte, want.string_done,
                     res_data.byte_valid, res_data.out_byte, res_data.string_done);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_strings(700, 1'b1);
    test_random_strings(400, 1'b0);
    test_backpressure();
    test_random_strings(550, 1'b1);
    chr_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
